/* design/rgbhsi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsi_pkg
// Shared types and constants of the rgb to hsi pixel core.
// ----------------------------------------------------------------------------
package rgbhsi_pkg;

  localparam int CordicSteps = 24;
  localparam int FracBits    = 24;
  localparam int AccW        = 36;
  localparam logic [25:0] Sqrt3Q24 = 26'd29058990;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;

  typedef logic signed [AccW-1:0] acc_t;

  // saturation collects quotient bits while rem/den run the divide
  typedef struct packed {
    logic [7:0]  intensity;
    logic [7:0]  saturation;
    logic        hue_en;
    logic [17:0] rem;
    logic [9:0]  den;
  } side_t;

  typedef struct packed {
    acc_t        x;
    acc_t        y;
    logic [31:0] ang;
  } cordic_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // signed division by 2^s, truncating toward zero
  function automatic acc_t sdiv_pow2(input acc_t v, input int s);
    acc_t q;
    acc_t mask;
    mask = acc_t'((64'sd1 <<< s) - 64'sd1);
    q = v >>> s;
    if (v[AccW-1] && ((v & mask) != '0)) q = q + acc_t'(1);
    return q;
  endfunction

endpackage
`default_nettype wire

/* design/rgbhsi_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsi_pix_if / rgbhsi_hsi_if
// Valid/ready channels for input pixels and hsi results.
// ----------------------------------------------------------------------------
interface rgbhsi_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface

interface rgbhsi_hsi_if;
  logic       valid;
  logic       ready;
  logic [7:0] intensity;
  logic [7:0] saturation;
  logic [7:0] hue_byte;
  logic [8:0] hue_degrees;
  modport source (output valid, intensity, saturation, hue_byte, hue_degrees,
                  input ready);
  modport sink   (input valid, intensity, saturation, hue_byte, hue_degrees,
                  output ready);
endinterface
`default_nettype wire

/* design/rgbhsi_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsi_front
// First stage: intensity, saturation divide setup and cordic start vector.
// ----------------------------------------------------------------------------
module rgbhsi_front
  import rgbhsi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  output side_t           side_r,
  output cordic_t         vec_r
);

  logic [9:0]  sum;
  logic [7:0]  mn;
  logic [9:0]  diff;
  logic [17:0] num;
  logic [19:0] isum;
  logic [7:0]  inten;
  acc_t        x0, y0, t;
  side_t       side_nxt;
  cordic_t     vec_nxt;

  always_comb begin
    sum = 10'(red) + 10'(green) + 10'(blue);
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    diff = sum - 10'(3 * 10'(mn));
    num = 18'(diff) * 18'd255;
    // divide by 3 as multiply by 683 / 2048, exact for sums up to 765
    isum = 20'(sum) * 20'd683;
    inten = isum[18:11];
    side_nxt.intensity = inten;
    side_nxt.saturation = 8'd0;
    side_nxt.hue_en = (diff != '0);
    side_nxt.rem = num;
    // black pixel: numerator is zero, a unit divisor keeps the quotient zero
    side_nxt.den = (sum != '0) ? sum : 10'd1;
    x0 = acc_t'($signed({2'b0, red, 1'b0}) - $signed(11'(green))
         - $signed(11'(blue))) <<< FracBits;
    y0 = acc_t'($signed({1'b0, green}) - $signed({1'b0, blue}))
         * acc_t'({1'b0, Sqrt3Q24});
    t = x0;
    vec_nxt.x = x0;
    vec_nxt.y = y0;
    vec_nxt.ang = '0;
    if (x0[AccW-1]) begin
      if (!y0[AccW-1]) begin
        vec_nxt.x = y0;
        vec_nxt.y = -t;
        vec_nxt.ang = QuarterTurn;
      end else begin
        vec_nxt.x = -y0;
        vec_nxt.y = t;
        vec_nxt.ang = -QuarterTurn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      vec_r  <= vec_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/rgbhsi_cordic_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsi_cordic_stage
// Two vectoring iterations per register stage, plus one saturation
// quotient bit in the first eight stages.
// ----------------------------------------------------------------------------
module rgbhsi_cordic_stage
  import rgbhsi_pkg::*;
#(
  parameter int Base = 0
) (
  input  wire logic    clk,
  input  wire logic    en,
  input  wire cordic_t vec,
  input  wire side_t   side,
  output cordic_t      vec_r,
  output side_t        side_r
);

  localparam int DivIdx = Base / 2;
  localparam bit DivOn  = (DivIdx < 8);
  localparam int DivBit = DivOn ? 7 - DivIdx : 0;

  cordic_t     a, b;
  side_t       side_nxt;
  logic [17:0] dsh;

  function automatic cordic_t step(input cordic_t v, input int i);
    cordic_t o;
    acc_t xs, ys;
    xs = sdiv_pow2(v.x, i);
    ys = sdiv_pow2(v.y, i);
    if (!v.y[AccW-1] && v.y != '0) begin
      o.x = v.x + ys;
      o.y = v.y - xs;
      o.ang = v.ang + atan_turn(5'(i));
    end else begin
      o.x = v.x - ys;
      o.y = v.y + xs;
      o.ang = v.ang - atan_turn(5'(i));
    end
    return o;
  endfunction

  always_comb begin
    a = step(vec, Base);
    b = step(a, Base + 1);
    // restoring divide, most significant quotient bit first
    side_nxt = side;
    dsh = 18'(side.den) << DivBit;
    if (DivOn && (side.rem >= dsh)) begin
      side_nxt.rem = side.rem - dsh;
      side_nxt.saturation[DivBit] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r  <= b;
      side_r <= side_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/rgb_to_hsi_pixel_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// stages from input transfer to result: front, 12 cordic, output
// saturation divide runs one quotient bit per cordic stage in the first eight
// throughput: one pixel per cycle while the output stage can take it; all stages advance together
// the output stage frees its slot whenever the sink is ready or it is empty
// reset: synchronous active-low rst_n clears all valid bits; data is not reset
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel_core
// Pipelined rgb to hsi conversion with a cordic hue angle.
// ----------------------------------------------------------------------------
module rgb_to_hsi_pixel_core
  import rgbhsi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  rgbhsi_pix_if.sink    in_ch,
  rgbhsi_hsi_if.source  out_ch
);

  localparam int NStg = CordicSteps / 2;
  localparam int NV   = NStg + 2;

  logic [NV-1:0] vld_r;
  logic          adv;
  cordic_t       vec [NStg+1];
  side_t         side [NStg+1];
  logic [7:0]    hb_r, hb_nxt;
  logic [8:0]    hd_r, hd_nxt;
  side_t         sside_r;
  logic          sval_r;

  assign adv = !vld_r[NV-1] || out_ch.ready;
  assign in_ch.ready = adv;

  rgbhsi_front u_front (
    .clk(clk), .en(adv), .red(in_ch.red), .green(in_ch.green),
    .blue(in_ch.blue), .side_r(side[0]), .vec_r(vec[0])
  );

  for (genvar k = 0; k < NStg; k++) begin : g_cor
    rgbhsi_cordic_stage #(.Base(2 * k)) u_stg (
      .clk(clk), .en(adv), .vec(vec[k]), .side(side[k]),
      .vec_r(vec[k+1]), .side_r(side[k+1])
    );
  end

  always_comb begin
    logic [39:0] p1;
    logic [40:0] p2;
    p1 = 40'(vec[NStg].ang) * 40'd255;
    p2 = 41'(vec[NStg].ang) * 41'd359;
    hb_nxt = side[NStg].hue_en ? p1[39:32] : 8'd0;
    hd_nxt = side[NStg].hue_en ? p2[40:32] : 9'd0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hb_r    <= hb_nxt;
      hd_r    <= hd_nxt;
      sside_r <= side[NStg];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_ch.valid};
    end
  end

  assign sval_r = vld_r[NV-1];
  assign out_ch.valid       = sval_r;
  assign out_ch.intensity   = sside_r.intensity;
  assign out_ch.saturation  = sside_r.saturation;
  assign out_ch.hue_byte    = hb_r;
  assign out_ch.hue_degrees = hd_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (vld_r == $past(vld_r)))
    else $error("pipeline moved during stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("not ready with empty output");
  a_hd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.hue_degrees <= 9'd359))
    else $error("hue degrees out of range");

endmodule
`default_nettype wire
